>>> rtl/whs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_pkg
// Shared types and constants of the weighted history smoother.
// ----------------------------------------------------------------------------
package whs_pkg;

  localparam int HistoryDepthDef = 10;

  localparam int InW    = 16;  // width of one movement delta
  localparam int OutW   = 24;  // width of one smoothed value, Q15.8
  localparam int RatioW = 16;  // weight ratio, unsigned Q0.16
  localparam int WeightW = 17; // weight, unsigned Q1.16
  localparam int QuotW  = 24;  // quotient bits of the rounding divider
  localparam int FracW  = 8;   // fractional bits of the filtered value

  localparam logic [RatioW-1:0]  RatioReset = 16'd13107;
  localparam logic [WeightW-1:0] WeightOne  = 17'h10000;
  localparam logic [OutW-1:0]    SmoothMax  = 24'h7FFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_OUTPUT
  } whs_state_e;

  typedef struct packed {
    logic hist_load;  // shift the new item into the history
    logic mac_init;   // clear sums, restart weight at one
    logic mac_step;   // accumulate one history entry
    logic div_load;   // set up the divider for one axis
    logic div_step;   // one quotient bit
    logic div_store;  // keep the filtered value of the axis
    logic axis;       // 0: x, 1: y
    logic out_load;   // form the result and load the output register
  } whs_cmd_t;

  typedef struct packed {
    logic mac_last;
    logic div_last;
  } whs_status_t;

endpackage

>>> rtl/weighted_history_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_history_smoother
// Geometric-weighted history average of pointer movement, two-frame mean.
// ----------------------------------------------------------------------------
// Each item (delta_x, delta_y) is shifted into a history of HISTORY_DEPTH
// entries; entry i is weighted by weight_ratio^i, the weighted mean is taken
// per axis with rounding to Q15.8, and the output is the floor mean of this
// value and the previous one. After its item is accepted, the walk reads one
// history entry per cycle, then a single shared divider produces one
// quotient bit per cycle, first for x, then for y, with one setup and one
// store step per axis, and then the result enters the output register. The
// next item is accepted in the cycle after the result enters the output
// register, even while that result still waits to be taken. A result that
// is still waiting when the next one is ready holds the block in its last
// step, and with it the input, until the waiting result is taken.
module weighted_history_smoother #(
  parameter int HISTORY_DEPTH = whs_pkg::HistoryDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [whs_pkg::RatioW-1:0]    cfg_wdata_i,    // weight_ratio
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*whs_pkg::InW-1:0]     s_axis_tdata,   // [15:0] delta_x, [31:16] delta_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*whs_pkg::OutW-1:0]    m_axis_tdata    // [23:0] smooth_x, [47:24] smooth_y
);
  import whs_pkg::*;

  whs_cmd_t    cmd;
  whs_status_t status;

  whs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  whs_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mac_step || cmd.div_step || cmd.div_load) |-> !s_axis_tready)
    else $error("item accepted while the walk or divider is busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten before its item was taken");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted right after the first");

  a_result_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

>>> rtl/whs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_datapath
// History line, multiply-accumulate walk, shared rounding divider and
// output register of the smoother.
// ----------------------------------------------------------------------------
module whs_datapath #(
  parameter int HISTORY_DEPTH = whs_pkg::HistoryDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [whs_pkg::RatioW-1:0]     cfg_wdata_i,
  input  logic [2*whs_pkg::InW-1:0]      in_data_i,
  input  whs_pkg::whs_cmd_t              cmd_i,
  output whs_pkg::whs_status_t           status_o,
  output logic [2*whs_pkg::OutW-1:0]     out_data_o
);
  import whs_pkg::*;

  localparam int DepthLog = $clog2(HISTORY_DEPTH);
  localparam int SumW     = 33 + DepthLog;
  localparam int TotW     = WeightW + DepthLog;
  localparam int NumW     = SumW + FracW + 1;
  localparam int CmpW     = (NumW > TotW + QuotW) ? NumW : TotW + QuotW;
  localparam int CntMax   = (HISTORY_DEPTH > QuotW) ? HISTORY_DEPTH : QuotW;
  localparam int CntW     = $clog2(CntMax);

  logic [RatioW-1:0]        ratio_q;
  logic signed [InW-1:0]    hx_q [HISTORY_DEPTH];
  logic signed [InW-1:0]    hy_q [HISTORY_DEPTH];
  logic [WeightW-1:0]       w_q;
  logic signed [SumW-1:0]   sum_x_q, sum_y_q;
  logic [TotW-1:0]          total_q;
  logic [CntW-1:0]          step_q;
  logic [CmpW-1:0]          rem_q, dsh_q;
  logic [QuotW-1:0]         quot_q;
  logic                     neg_q;
  logic signed [OutW-1:0]   cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic signed [OutW-1:0]   out_x_q, out_y_q;

  logic signed [InW+WeightW:0] prod_x, prod_y;
  logic [WeightW+RatioW-1:0]   w_prod;
  logic signed [SumW-1:0]      sum_sel;
  logic [SumW-1:0]             mag;
  logic [CmpW-1:0]             num;
  logic                        rem_ge;
  logic signed [OutW-1:0]      cur_val;
  logic signed [OutW:0]        mix_x, mix_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset;
    end else if (cfg_we_i) begin
      ratio_q <= cfg_wdata_i;
    end
  end

  // History line: insert at the head, rotate toward the head during the walk
  // so that the entry in use always sits at position zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hx_q[k] <= '0;
        hy_q[k] <= '0;
      end
    end else if (cmd_i.hist_load) begin
      hx_q[0] <= in_data_i[InW-1:0];
      hy_q[0] <= in_data_i[2*InW-1:InW];
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
        hx_q[k] <= hx_q[k-1];
        hy_q[k] <= hy_q[k-1];
      end
    end else if (cmd_i.mac_step) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        hx_q[k] <= hx_q[k+1];
        hy_q[k] <= hy_q[k+1];
      end
      hx_q[HISTORY_DEPTH-1] <= hx_q[0];
      hy_q[HISTORY_DEPTH-1] <= hy_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.mac_init || cmd_i.div_load) begin
      step_q <= '0;
    end else if (cmd_i.mac_step || cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  assign status_o.mac_last = (step_q == CntW'(HISTORY_DEPTH - 1));
  assign status_o.div_last = (step_q == CntW'(QuotW - 1));

  assign prod_x = hx_q[0] * $signed({1'b0, w_q});
  assign prod_y = hy_q[0] * $signed({1'b0, w_q});
  assign w_prod = w_q * ratio_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_init) begin
      w_q     <= WeightOne;
      sum_x_q <= '0;
      sum_y_q <= '0;
      total_q <= '0;
    end else if (cmd_i.mac_step) begin
      w_q     <= w_prod[WeightW+RatioW-1:RatioW];
      sum_x_q <= sum_x_q + SumW'(prod_x);
      sum_y_q <= sum_y_q + SumW'(prod_y);
      total_q <= total_q + TotW'(w_q);
    end
  end

  // Rounding divider: magnitude * 256 plus half the total, one bit a cycle.
  assign sum_sel = cmd_i.axis ? sum_y_q : sum_x_q;
  assign mag     = sum_sel[SumW-1] ? SumW'(-sum_sel) : SumW'(sum_sel);
  assign num     = CmpW'({mag, {FracW{1'b0}}}) + CmpW'(total_q >> 1);
  assign rem_ge  = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= num;
      dsh_q  <= CmpW'(total_q) << (QuotW - 1);
      quot_q <= '0;
      neg_q  <= sum_sel[SumW-1];
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[QuotW-2:0], rem_ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  // Saturate: the quotient never exceeds 2^23, which only overflows upward.
  assign cur_val = neg_q ? -$signed(quot_q)
                         : (quot_q[QuotW-1] ? $signed(SmoothMax) : $signed(quot_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      if (cmd_i.axis) begin
        cur_y_q <= cur_val;
      end else begin
        cur_x_q <= cur_val;
      end
    end
  end

  assign mix_x = {cur_x_q[OutW-1], cur_x_q} + {prev_x_q[OutW-1], prev_x_q};
  assign mix_y = {cur_y_q[OutW-1], cur_y_q} + {prev_y_q[OutW-1], prev_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (cmd_i.out_load) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
  end

  // Halve with floor: drop the low bit of the two-frame sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q <= mix_x[OutW:1];
      out_y_q <= mix_y[OutW:1];
    end
  end

  assign out_data_o = {out_y_q, out_x_q};

endmodule

>>> rtl/whs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_ctrl
// Sequencer of the smoother: input handshake, walk, divider passes for both
// axes and the output register's valid flag.
// ----------------------------------------------------------------------------
module whs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  input  whs_pkg::whs_status_t  status_i,
  output whs_pkg::whs_cmd_t     cmd_o
);
  import whs_pkg::*;

  whs_state_e state_q, state_d;
  logic       axis_q, axis_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    cmd_o     = '0;
    cmd_o.axis = axis_q;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.hist_load = 1'b1;
          cmd_o.mac_init  = 1'b1;
          state_d         = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (status_i.mac_last) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        if (axis_q) begin
          state_d = ST_OUTPUT;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_DIV_LOAD;
        end
      end
      ST_OUTPUT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          axis_d         = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the weighted history smoother.
// ----------------------------------------------------------------------------
// Each accepted item runs through a local model of the geometric history
// average and the two-frame floor mean. The model queues the smoothed pair,
// and every item taken from the output stream is compared field by field
// against the oldest queued pair. The stimulus starts with a short directed
// part: field extremes, zero ratio and a ratio just below one. It then
// sends long random runs under several ratio settings. Both stream sides
// idle at random, and a long output stall and full drain pauses are
// also exercised.
// ----------------------------------------------------------------------------
module testbench;
  import whs_pkg::*;

  localparam int Depth       = HistoryDepthDef;
  localparam int ItemLatency = Depth + 2 * 26 + 2;
  localparam int IdleLimit   = 4000;
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 290;

  localparam logic signed [InW-1:0] DeltaMax = 16'sh7FFF;
  localparam logic signed [InW-1:0] DeltaMin = 16'sh8000;
  localparam logic [RatioW-1:0] RatioZero    = 16'h0000;
  localparam logic [RatioW-1:0] RatioNearOne = 16'hFFFF;
  localparam logic [RatioW-1:0] RatioHalf    = 16'h8000;

  localparam longint SmoothHi = (longint'(1) <<< (OutW - 1)) - 1;
  localparam longint SmoothLo = -(longint'(1) <<< (OutW - 1));

  typedef struct packed {
    logic signed [OutW-1:0] smooth_y;
    logic signed [OutW-1:0] smooth_x;
  } smooth_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [RatioW-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*InW-1:0]    s_axis_tdata  = '0;   // [15:0] delta_x, [31:16] delta_y
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [2*OutW-1:0]   m_axis_tdata;         // [23:0] smooth_x, [47:24] smooth_y

  // model state
  logic [RatioW-1:0]     ratio_model;
  logic signed [InW-1:0] hist_x [Depth];
  logic signed [InW-1:0] hist_y [Depth];
  logic signed [OutW-1:0] prev_x;
  logic signed [OutW-1:0] prev_y;
  smooth_t               smooth_q [$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int rx_cycle       = 0;
  int rx_mode        = 0;
  int burst_left     = 0;
  bit gaps_on        = 1'b1;

  weighted_history_smoother dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic signed [OutW-1:0] round_mean(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned q;
    longint          r;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (q > longint'(1) << (OutW - 1)) q = longint'(1) << (OutW - 1);
    r = (num < 0) ? -longint'(q) : longint'(q);
    if (r > SmoothHi) r = SmoothHi;
    if (r < SmoothLo) r = SmoothLo;
    return OutW'(r);
  endfunction

  function automatic void smooth_item(input logic signed [InW-1:0] dx,
                                      input logic signed [InW-1:0] dy);
    longint                 sum_x;
    longint                 sum_y;
    longint                 total;
    longint unsigned        w;
    logic signed [OutW-1:0] cur_x;
    logic signed [OutW-1:0] cur_y;
    int                     mean_x;
    int                     mean_y;
    smooth_t                res;
    sum_x = 0;
    sum_y = 0;
    total = 0;
    w = 64'd65536;
    for (int i = Depth - 1; i > 0; i--) begin
      hist_x[i] = hist_x[i-1];
      hist_y[i] = hist_y[i-1];
    end
    hist_x[0] = dx;
    hist_y[0] = dy;
    for (int i = 0; i < Depth; i++) begin
      sum_x += longint'(hist_x[i]) * longint'(w);
      sum_y += longint'(hist_y[i]) * longint'(w);
      total += longint'(w);
      w = (w * ratio_model) >> 16;
    end
    cur_x = round_mean(sum_x * 256, total);
    cur_y = round_mean(sum_y * 256, total);
    // floor mean with the previous filtered value
    mean_x = int'(cur_x) + int'(prev_x);
    mean_y = int'(cur_y) + int'(prev_y);
    res.smooth_x = OutW'(mean_x >>> 1);
    res.smooth_y = OutW'(mean_y >>> 1);
    prev_x = cur_x;
    prev_y = cur_y;
    smooth_q.push_back(res);
  endfunction

  function automatic void clear_model();
    ratio_model = RatioReset;
    for (int i = 0; i < Depth; i++) begin
      hist_x[i] = '0;
      hist_y[i] = '0;
    end
    prev_x = '0;
    prev_y = '0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(input string what, input logic [OutW-1:0] want,
                               input logic [OutW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected %0d, got %0d", what, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    smooth_t got;
    smooth_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (smooth_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: x %0d, y %0d", got.smooth_x, got.smooth_y);
        end
      end else begin
        want = smooth_q.pop_front();
        if (got.smooth_x !== want.smooth_x) note_mismatch("smooth_x", want.smooth_x, got.smooth_x);
        if (got.smooth_y !== want.smooth_y) note_mismatch("smooth_y", want.smooth_y, got.smooth_y);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("weighted_history_smoother: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    rx_cycle++;
    if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_item(input logic signed [InW-1:0] dx, input logic signed [InW-1:0] dy);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dy, dx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    smooth_item(dx, dy);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (smooth_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [RatioW-1:0] ratio);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ratio;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ratio_model = ratio;
  endtask

  function automatic logic signed [InW-1:0] rand_delta(input logic signed [InW-1:0] last);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return InW'($urandom);
    if (pick < 7) return InW'(int'($urandom_range(0, 64)) - 32);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0:       return DeltaMax;
        1:       return DeltaMin;
        2:       return '0;
        default: return '1;
      endcase
    end
    // repeat the last value so the history fills with a constant run
    return last;
  endfunction

  task automatic send_random(input int count);
    logic signed [InW-1:0] dx;
    logic signed [InW-1:0] dy;
    dx = '0;
    dy = '0;
    repeat (count) begin
      dx = rand_delta(dx);
      dy = rand_delta(dy);
      send_item(dx, dy);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_ratio();
    send_item(DeltaMax, DeltaMin);
    send_item(DeltaMin, DeltaMax);
    send_item('0, '0);
    send_item('1, 16'sd1);
    send_item(DeltaMin, DeltaMin);
    send_item(DeltaMin, DeltaMin);
    send_item(DeltaMax, DeltaMax);
    send_item(DeltaMax, DeltaMax);
  endtask

  task automatic test_zero_ratio();
    write_ratio(RatioZero);
    send_item(DeltaMax, DeltaMin);
    send_item(DeltaMin, DeltaMax);
    send_item('1, '0);
    send_item(16'sd3, -16'sd3);
    send_item('0, '1);
  endtask

  task automatic test_ratio_near_one();
    write_ratio(RatioNearOne);
    // fill the whole history with one extreme, then swing to the other
    repeat (Depth) send_item(DeltaMin, DeltaMax);
    send_item(DeltaMax, DeltaMin);
    send_item(DeltaMax, DeltaMin);
  endtask

  task automatic test_output_stall();
    gaps_on  = 1'b0;
    hold_req = HoldCycles;
    // keep offering items so the block fills and holds off its input
    send_random(8);
    gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random(20);
    drain_results();
    send_random(20);
  endtask

  task automatic test_random_ratios();
    logic [RatioW-1:0] ratios [6];
    ratios[0] = RatioW'($urandom);
    ratios[1] = RatioZero;
    ratios[2] = RatioNearOne;
    ratios[3] = RatioW'($urandom);
    ratios[4] = RatioHalf;
    ratios[5] = 16'd1;
    for (int p = 0; p < 6; p++) begin
      write_ratio(ratios[p]);
      gaps_on = (p % 3 != 2);
      send_random(PhaseItems);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_ratio();
    test_zero_ratio();
    test_ratio_near_one();
    write_ratio(RatioReset);
    test_output_stall();
    test_sender_pause();
    test_random_ratios();

    drain_results();
    repeat (ItemLatency + 16) @(posedge clk_i);
    if (smooth_q.size() != 0) begin
      $display("%0d results never arrived", smooth_q.size());
      mismatch_count += smooth_q.size();
    end
    if (mismatch_count == 0) begin
      $display("weighted_history_smoother: match");
    end else begin
      $display("weighted_history_smoother: mismatch");
    end
    $finish;
  end

endmodule
